// ----- rtl/dltq_pkg.sv -----
// shared types and constants of the delta list timer queue
`default_nettype none

package dltq_pkg;

    localparam int DELTA_W   = 20;
    localparam int HANDLER_W = 8;
    localparam int ARG_W     = 32;
    localparam int KIND_W    = 2;
    localparam int OCC_W     = 4;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_ACCEPT   = 2'd0;
    localparam kind_t KIND_OVERFLOW = 2'd1;
    localparam kind_t KIND_FIRED    = 2'd2;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef struct packed {
        logic [DELTA_W-1:0]   delta;
        logic [HANDLER_W-1:0] handler;
        logic [ARG_W-1:0]     arg;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_WALK,
        ST_INS_SHIFT,
        ST_INS_PUT,
        ST_TICK_SCAN,
        ST_EMIT_RD,
        ST_EMIT_LOAD,
        ST_EMIT_WAIT,
        ST_PACK
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/dltq_ram.sv -----
// entry store: one write port, one read port with registered read data
`default_nettype none

module dltq_ram #(
    parameter int DEPTH = 16
) (
    input  wire                      clk,
    input  wire                      wr_en,
    input  wire  [$clog2(DEPTH)-1:0] wr_addr,
    input  dltq_pkg::entry_t         wr_data,
    input  wire  [$clog2(DEPTH)-1:0] rd_addr,
    output dltq_pkg::entry_t         rd_data
);

    dltq_pkg::entry_t mem [DEPTH];
    dltq_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/delta_list_timer_queue.sv -----
// top level: sorted callout queue held as a delta list, walked by a small sequencer
// operation: an insert walks the held entries, shifts the tail up where needed and writes
//   the new entry, an overflow is rejected, and each ends with its one item in the output register;
//   a tick scans up to the first nonzero delta, then emits each fired item and moves the survivors down
// throughput: one item at a time; set by the entry memory, one read and one write per cycle
// the block stalls input until its work is done and the output register is empty
// reset: queue empty at once (fill count cleared), no clearing pass over the memory
`default_nettype none

module delta_list_timer_queue #(
    parameter int DEPTH = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         command,
    input  wire  [7:0]  handler_id,
    input  wire  [31:0] argument,
    input  wire  [19:0] delay_ticks,
    input  wire         defer_firing,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  fired_handler,
    output logic [31:0] fired_argument,
    output logic        last,
    output logic [3:0]  occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH - 1);

    dltq_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] fired_reg, fired_next;
    logic [dltq_pkg::DELTA_W-1:0]   t_reg, t_next;
    logic [dltq_pkg::HANDLER_W-1:0] hid_reg, hid_next;
    logic [dltq_pkg::ARG_W-1:0]     arg_reg, arg_next;
    logic defer_reg, defer_next;
    logic dec_done_reg, dec_done_next;

    logic out_valid_reg, out_valid_next;
    dltq_pkg::kind_t kind_reg, kind_next;
    logic [dltq_pkg::HANDLER_W-1:0] fh_reg, fh_next;
    logic [dltq_pkg::ARG_W-1:0]     fa_reg, fa_next;
    logic last_reg, last_next;
    logic [dltq_pkg::OCC_W-1:0] occ_reg, occ_next;

    logic             ram_we;
    logic [AW-1:0]    ram_wa;
    logic [AW-1:0]    ram_ra;
    dltq_pkg::entry_t ram_wd;
    dltq_pkg::entry_t ram_rd;

    logic ready;
    logic in_accept;
    logic out_accept;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] pack_src;
    logic [CW-1:0] occ_left;
    logic [CW-1:0] scan_fired;
    logic          scan_finish;
    logic          scan_advance;

    dltq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    assign ready      = (state_reg == dltq_pkg::ST_IDLE) && !out_valid_reg;
    assign in_stall   = !ready;
    assign in_accept  = in_valid && ready;
    assign out_accept = out_valid_reg && !out_stall;

    assign idx_inc  = idx_reg + ONE;
    assign pos_inc  = pos_reg + ONE;
    assign pack_src = idx_reg + fired_reg + ONE;
    assign occ_left = count_reg - idx_reg - ONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dltq_pkg::ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            fired_reg     <= '0;
            defer_reg     <= 1'b0;
            dec_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            fired_reg     <= fired_next;
            defer_reg     <= defer_next;
            dec_done_reg  <= dec_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        hid_reg  <= hid_next;
        arg_reg  <= arg_next;
        kind_reg <= kind_next;
        fh_reg   <= fh_next;
        fa_reg   <= fa_next;
        last_reg <= last_next;
        occ_reg  <= occ_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        fired_next     = fired_reg;
        t_next         = t_reg;
        hid_next       = hid_reg;
        arg_next       = arg_reg;
        defer_next     = defer_reg;
        dec_done_next  = dec_done_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        fh_next        = fh_reg;
        fa_next        = fa_reg;
        last_next      = last_reg;
        occ_next       = occ_reg;
        ram_we         = 1'b0;
        ram_wa         = '0;
        ram_wd         = ram_rd;
        ram_ra         = '0;
        scan_finish    = 1'b0;
        scan_advance   = 1'b0;
        scan_fired     = '0;

        case (state_reg)
            dltq_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    idx_next      = '0;
                    t_next        = delay_ticks;
                    hid_next      = handler_id;
                    arg_next      = argument;
                    defer_next    = defer_firing;
                    dec_done_next = 1'b0;
                    if (command == dltq_pkg::CMD_INSERT)
                    begin
                        if (count_reg >= FULL)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = dltq_pkg::KIND_OVERFLOW;
                            fh_next        = '0;
                            fa_next        = '0;
                            last_next      = 1'b1;
                            occ_next       = dltq_pkg::OCC_W'(count_reg);
                        end
                        else if (count_reg == '0)
                        begin
                            pos_next   = '0;
                            state_next = dltq_pkg::ST_INS_PUT;
                        end
                        else
                        begin
                            state_next = dltq_pkg::ST_INS_WALK;
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        state_next = dltq_pkg::ST_TICK_SCAN;
                    end
                end
            end

            dltq_pkg::ST_INS_WALK:
            begin
                if (ram_rd.delta <= t_reg)
                begin
                    t_next = t_reg - ram_rd.delta;
                    if (idx_inc == count_reg)
                    begin
                        pos_next   = count_reg;
                        state_next = dltq_pkg::ST_INS_PUT;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        ram_ra   = idx_inc[AW-1:0];
                    end
                end
                else
                begin
                    // open a slot at this entry: shift the tail up from the end
                    pos_next   = idx_reg;
                    idx_next   = count_reg;
                    ram_ra     = AW'(count_reg - ONE);
                    state_next = dltq_pkg::ST_INS_SHIFT;
                end
            end

            dltq_pkg::ST_INS_SHIFT:
            begin
                ram_we = 1'b1;
                ram_wa = idx_reg[AW-1:0];
                // the old entry at the insert point becomes the successor
                if (idx_reg == pos_inc)
                begin
                    ram_wd.delta = ram_rd.delta - t_reg;
                    state_next   = dltq_pkg::ST_INS_PUT;
                end
                ram_ra   = AW'(idx_reg - CW'(2));
                idx_next = idx_reg - ONE;
            end

            dltq_pkg::ST_INS_PUT:
            begin
                ram_we         = 1'b1;
                ram_wa         = pos_reg[AW-1:0];
                ram_wd.delta   = t_reg;
                ram_wd.handler = hid_reg;
                ram_wd.arg     = arg_reg;
                count_next     = count_reg + ONE;
                out_valid_next = 1'b1;
                kind_next      = dltq_pkg::KIND_ACCEPT;
                fh_next        = '0;
                fa_next        = '0;
                last_next      = 1'b1;
                occ_next       = dltq_pkg::OCC_W'(count_reg + ONE);
                state_next     = dltq_pkg::ST_IDLE;
            end

            dltq_pkg::ST_TICK_SCAN:
            begin
                if (!dec_done_reg && ram_rd.delta != '0)
                begin
                    ram_we        = 1'b1;
                    ram_wa        = idx_reg[AW-1:0];
                    ram_wd.delta  = ram_rd.delta - dltq_pkg::DELTA_W'(1);
                    dec_done_next = 1'b1;
                    if (defer_reg)
                    begin
                        state_next = dltq_pkg::ST_IDLE;
                    end
                    else if (ram_rd.delta != dltq_pkg::DELTA_W'(1))
                    begin
                        scan_finish = 1'b1;
                        scan_fired  = idx_reg;
                    end
                    else
                    begin
                        scan_advance = 1'b1;
                    end
                end
                else if (ram_rd.delta != '0)
                begin
                    scan_finish = 1'b1;
                    scan_fired  = idx_reg;
                end
                else
                begin
                    scan_advance = 1'b1;
                end

                if (scan_advance)
                begin
                    if (idx_inc == count_reg)
                    begin
                        scan_finish = 1'b1;
                        scan_fired  = count_reg;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        ram_ra   = idx_inc[AW-1:0];
                    end
                end

                if (scan_finish)
                begin
                    fired_next = scan_fired;
                    idx_next   = '0;
                    if (scan_fired == '0 || defer_reg)
                    begin
                        state_next = dltq_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = dltq_pkg::ST_EMIT_RD;
                    end
                end
            end

            dltq_pkg::ST_EMIT_RD:
            begin
                ram_ra     = idx_reg[AW-1:0];
                state_next = dltq_pkg::ST_EMIT_LOAD;
            end

            dltq_pkg::ST_EMIT_LOAD:
            begin
                out_valid_next = 1'b1;
                kind_next      = dltq_pkg::KIND_FIRED;
                fh_next        = ram_rd.handler;
                fa_next        = ram_rd.arg;
                last_next      = (idx_inc == fired_reg);
                occ_next       = dltq_pkg::OCC_W'(occ_left);
                state_next     = dltq_pkg::ST_EMIT_WAIT;
            end

            dltq_pkg::ST_EMIT_WAIT:
            begin
                if (out_accept)
                begin
                    if (idx_inc != fired_reg)
                    begin
                        idx_next   = idx_inc;
                        state_next = dltq_pkg::ST_EMIT_RD;
                    end
                    else if (fired_reg == count_reg)
                    begin
                        count_next = '0;
                        state_next = dltq_pkg::ST_IDLE;
                    end
                    else
                    begin
                        // move the survivors down over the fired entries
                        idx_next   = '0;
                        ram_ra     = fired_reg[AW-1:0];
                        state_next = dltq_pkg::ST_PACK;
                    end
                end
            end

            dltq_pkg::ST_PACK:
            begin
                ram_we   = 1'b1;
                ram_wa   = idx_reg[AW-1:0];
                ram_ra   = pack_src[AW-1:0];
                idx_next = idx_inc;
                if (pack_src == count_reg)
                begin
                    count_next = count_reg - fired_reg;
                    state_next = dltq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dltq_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign fired_handler  = fh_reg;
    assign fired_argument = fa_reg;
    assign last           = last_reg;
    assign occupancy      = occ_reg;

    // the queue never holds more than one entry short of the table
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL)
        else $error("queue fill count beyond capacity");

    // an insert grows the queue by exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg > $past(count_reg) |-> count_reg == $past(count_reg) + ONE)
        else $error("fill count grew by more than one");

    // an overflow item reports a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == dltq_pkg::KIND_OVERFLOW
        |-> occ_reg == dltq_pkg::OCC_W'(FULL))
        else $error("overflow reported on a queue that is not full");

    // no new item is taken while a result still waits
    assert property (@(posedge clk) disable iff (!rst_n) in_accept |-> !out_valid_reg)
        else $error("item accepted with a result pending");

    // a fired item always comes from the fired prefix, which never runs past the held entries
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == dltq_pkg::KIND_FIRED
        |-> idx_reg < fired_reg && fired_reg <= count_reg)
        else $error("fired item outside the fired prefix");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// self-checking testbench for the delta list timer queue
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;
    localparam int RANDOM_ITEMS = 380;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        dltq_pkg::kind_t                kind;
        logic [dltq_pkg::HANDLER_W-1:0] handler;
        logic [dltq_pkg::ARG_W-1:0]     arg;
        logic                           last;
        logic [dltq_pkg::OCC_W-1:0]     occ;
    } callout_result_t;

    class callout_scoreboard;
        logic [dltq_pkg::DELTA_W-1:0]   slot_delta   [QUEUE_DEPTH];
        logic [dltq_pkg::HANDLER_W-1:0] slot_handler [QUEUE_DEPTH];
        logic [dltq_pkg::ARG_W-1:0]     slot_arg     [QUEUE_DEPTH];
        int held;
        callout_result_t due_results[$];
        int errors;
        int checked;
        int fired;
        int accepted;
        int rejected;

        function new();
            held = 0;
            errors = 0;
            checked = 0;
            fired = 0;
            accepted = 0;
            rejected = 0;
        endfunction

        function void push_result(dltq_pkg::kind_t k, logic [dltq_pkg::HANDLER_W-1:0] h,
                                  logic [dltq_pkg::ARG_W-1:0] a, logic l, int occ);
            callout_result_t r;
            r.kind = k;
            r.handler = h;
            r.arg = a;
            r.last = l;
            r.occ = occ[dltq_pkg::OCC_W-1:0];
            due_results.push_back(r);
        endfunction

        // updates the held list for one accepted item and queues what it must produce
        function void apply_command(logic cmd, logic [dltq_pkg::HANDLER_W-1:0] h,
                                    logic [dltq_pkg::ARG_W-1:0] a,
                                    logic [dltq_pkg::DELTA_W-1:0] d, logic df);
            int n;
            int pos;
            int i;
            int nfire;
            bit hit;
            logic [dltq_pkg::DELTA_W-1:0] rest;
            n = held;
            if (cmd == dltq_pkg::CMD_INSERT) begin
                rest = d;
                pos = 0;
                // equal firing times walk past held entries
                while (pos < n && slot_delta[pos] <= rest) begin
                    rest -= slot_delta[pos];
                    pos++;
                end
                if (n >= QUEUE_DEPTH - 1) begin
                    push_result(dltq_pkg::KIND_OVERFLOW, '0, '0, 1'b1, n);
                    rejected++;
                end else begin
                    if (pos < n)
                        slot_delta[pos] -= rest;
                    for (i = n; i > pos; i--) begin
                        slot_delta[i] = slot_delta[i-1];
                        slot_handler[i] = slot_handler[i-1];
                        slot_arg[i] = slot_arg[i-1];
                    end
                    slot_delta[pos] = rest;
                    slot_handler[pos] = h;
                    slot_arg[pos] = a;
                    held = n + 1;
                    push_result(dltq_pkg::KIND_ACCEPT, '0, '0, 1'b1, n + 1);
                    accepted++;
                end
            end else if (n > 0) begin
                hit = 1'b0;
                for (i = 0; i < n && !hit; i++) begin
                    if (slot_delta[i] != '0) begin
                        slot_delta[i] -= 1'b1;
                        hit = 1'b1;
                    end
                end
                if (!df) begin
                    nfire = 0;
                    while (nfire < n && slot_delta[nfire] == '0)
                        nfire++;
                    for (i = 0; i < nfire; i++)
                        push_result(dltq_pkg::KIND_FIRED, slot_handler[i], slot_arg[i],
                                    (i + 1 == nfire), n - i - 1);
                    for (i = 0; i + nfire < n; i++) begin
                        slot_delta[i] = slot_delta[i+nfire];
                        slot_handler[i] = slot_handler[i+nfire];
                        slot_arg[i] = slot_arg[i+nfire];
                    end
                    held = n - nfire;
                    fired += nfire;
                end
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check(dltq_pkg::kind_t k, logic [dltq_pkg::HANDLER_W-1:0] h,
                   logic [dltq_pkg::ARG_W-1:0] a, logic l,
                   logic [dltq_pkg::OCC_W-1:0] occ);
            callout_result_t r;
            checked++;
            if (due_results.size() == 0) begin
                report($sformatf("unexpected result kind %0d handler %0d", k, h));
            end else begin
                r = due_results.pop_front();
                if (k !== r.kind)
                    report($sformatf("kind %0d, want %0d", k, r.kind));
                if (h !== r.handler)
                    report($sformatf("handler %0d, want %0d", h, r.handler));
                if (a !== r.arg)
                    report($sformatf("argument %h, want %h", a, r.arg));
                if (l !== r.last)
                    report($sformatf("last %b, want %b", l, r.last));
                if (occ !== r.occ)
                    report($sformatf("occupancy %0d, want %0d", occ, r.occ));
            end
        endtask

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           command = dltq_pkg::CMD_TICK;
    logic [dltq_pkg::HANDLER_W-1:0] handler_id = '0;
    logic [dltq_pkg::ARG_W-1:0]     argument = '0;
    logic [dltq_pkg::DELTA_W-1:0]   delay_ticks = '0;
    logic                           defer_firing = 1'b0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [dltq_pkg::KIND_W-1:0]    kind;
    logic [dltq_pkg::HANDLER_W-1:0] fired_handler;
    logic [dltq_pkg::ARG_W-1:0]     fired_argument;
    logic                           last;
    logic [dltq_pkg::OCC_W-1:0]     occupancy;

    callout_scoreboard sb;
    bit idle_on = 1'b0;
    bit stall_on = 1'b0;
    int cycles = 0;

    delta_list_timer_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .handler_id(handler_id),
        .argument(argument),
        .delay_ticks(delay_ticks),
        .defer_firing(defer_firing),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .fired_handler(fired_handler),
        .fired_argument(fired_argument),
        .last(last),
        .occupancy(occupancy)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check(kind, fired_handler, fired_argument, last, occupancy);
    end

    // receiver stalls in random bursts while stall_on is set
    initial
    begin
        int left;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0 && stall_on && $urandom_range(0, 5) == 0)
                left = $urandom_range(1, 8);
            out_stall <= (left != 0);
            if (left != 0)
                left--;
        end
    end

    task automatic issue(logic cmd, logic [dltq_pkg::HANDLER_W-1:0] h,
                         logic [dltq_pkg::ARG_W-1:0] a,
                         logic [dltq_pkg::DELTA_W-1:0] d, logic df);
        in_valid <= 1'b1;
        command <= cmd;
        handler_id <= h;
        argument <= a;
        delay_ticks <= d;
        defer_firing <= df;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.apply_command(cmd, h, a, d, df);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int k;
        int pick;
        int sel;
        logic [dltq_pkg::DELTA_W-1:0] d;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;
        stall_on = 1'b1;

        // tick on an empty queue with junk in the unused fields
        issue(dltq_pkg::CMD_TICK, 8'hFF, 32'hFFFF_FFFF, 20'hFFFFF, 1'b0);
        issue(dltq_pkg::CMD_INSERT, 8'h00, 32'h0000_0000, 20'h00000, 1'b1);
        issue(dltq_pkg::CMD_INSERT, 8'h11, $urandom, 20'h00000, 1'b0);
        // no positive delta left, deferred then live
        issue(dltq_pkg::CMD_TICK, 8'($urandom_range(0, 255)), $urandom,
              20'($urandom_range(0, 20'hFFFFF)), 1'b1);
        issue(dltq_pkg::CMD_TICK, 8'($urandom_range(0, 255)), $urandom,
              20'($urandom_range(0, 20'hFFFFF)), 1'b0);
        // fill to capacity with one shared firing time, then one more
        for (k = 0; k < QUEUE_DEPTH - 1; k++)
            issue(dltq_pkg::CMD_INSERT, 8'($urandom_range(0, 255)), $urandom, 20'd2,
                  1'($urandom_range(0, 1)));
        issue(dltq_pkg::CMD_INSERT, 8'hA5, $urandom, 20'($urandom_range(0, 20'hFFFFF)), 1'b0);
        issue(dltq_pkg::CMD_TICK, 8'($urandom_range(0, 255)), $urandom,
              20'($urandom_range(0, 20'hFFFFF)), 1'b1);
        issue(dltq_pkg::CMD_TICK, 8'($urandom_range(0, 255)), $urandom,
              20'($urandom_range(0, 20'hFFFFF)), 1'b0);
        issue(dltq_pkg::CMD_INSERT, 8'hFF, 32'hFFFF_FFFF, 20'hFFFFF, 1'b0);
        issue(dltq_pkg::CMD_INSERT, 8'($urandom_range(0, 255)), $urandom, 20'd7, 1'b0);
        issue(dltq_pkg::CMD_TICK, 8'($urandom_range(0, 255)), $urandom,
              20'($urandom_range(0, 20'hFFFFF)), 1'b0);
        wait_drained();

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS / 2)
                wait_drained();
            if (k == RANDOM_ITEMS - 80)
            begin
                idle_on = 1'b0;
                stall_on = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < ((sb.held < 12) ? 55 : 35))
            begin
                // mostly short delays so entries come due, a few that stay parked
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    d = 20'($urandom_range(0, 6));
                else if (sel < 93)
                    d = 20'($urandom_range(0, 40));
                else if (sel < 98)
                    d = 20'($urandom_range(0, 300));
                else
                    d = 20'($urandom_range(0, 20'hFFFFF));
                issue(dltq_pkg::CMD_INSERT, 8'($urandom_range(0, 255)), $urandom, d,
                      1'($urandom_range(0, 1)));
            end
            else
            begin
                issue(dltq_pkg::CMD_TICK, 8'($urandom_range(0, 255)), $urandom,
                      20'($urandom_range(0, 20'hFFFFF)), ($urandom_range(0, 4) == 0));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d accepted inserts, %0d overflow rejections, %0d fired entries",
                 sb.accepted, sb.rejected, sb.fired);
        $display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
